// ----- rtl/weighted_random_select_unit_defines.svh -----
// Assertion helpers shared by the weighted selection block
`ifndef WEIGHTED_RANDOM_SELECT_UNIT_DEFINES_SVH
`define WEIGHTED_RANDOM_SELECT_UNIT_DEFINES_SVH

// same-cycle implication, masked during reset
`define WRS_ASSERT_NOW(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("wrs: same-cycle check failed");

// next-cycle implication, masked during reset
`define WRS_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("wrs: next-cycle check failed");

`endif

// ----- rtl/wrs_pkg.sv -----
package wrs_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int WEIGHT_BITS = 16;

  localparam int IDX_BITS   = $clog2(MAX_ENTRIES);
  localparam int CNT_BITS   = $clog2(MAX_ENTRIES + 1);
  localparam int TOTAL_BITS = WEIGHT_BITS + IDX_BITS;

  // fixed field widths of the channels
  localparam int MODE_BITS      = 2;
  localparam int WEIGHT_IN_BITS = 16;
  localparam int RAND_BITS      = 31;
  localparam int INDEX_OUT_BITS = 4;
  localparam int STATUS_BITS    = 2;
  localparam int STEP_BITS      = $clog2(RAND_BITS);

  localparam logic [MODE_BITS-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_APPEND = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_DRAW   = 2'd2;

  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_NONE  = 2'd3;

  typedef struct packed {
    logic accept;
    logic mod_step;
    logic load;
    logic walk_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic draw_go;
    logic mod_last;
    logic hit;
    logic last;
  } sts_t;

endpackage

// ----- rtl/wrs_in_if.sv -----
interface wrs_in_if import wrs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [MODE_BITS-1:0]      mode;
  logic [WEIGHT_IN_BITS-1:0] weight_value;
  logic [RAND_BITS-1:0]      random_word;

  modport source (output valid, mode, weight_value, random_word, input ready);
  modport sink   (input valid, mode, weight_value, random_word, output ready);
endinterface

// ----- rtl/wrs_out_if.sv -----
interface wrs_out_if import wrs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [INDEX_OUT_BITS-1:0] chosen_index;
  logic [STATUS_BITS-1:0]    status;

  modport source (output valid, chosen_index, status, input ready);
  modport sink   (input valid, chosen_index, status, output ready);
endinterface

// ----- rtl/wrs_mod.sv -----
module wrs_mod import wrs_pkg::*; (
  input  logic                  clk,
  input  logic                  start,
  input  logic                  step,
  input  logic [RAND_BITS-1:0]  dividend,
  input  logic [TOTAL_BITS-1:0] divisor,
  output logic [TOTAL_BITS-1:0] rem,
  output logic                  last
);

  logic [RAND_BITS-1:0]  dsr;
  logic [STEP_BITS-1:0]  cnt;
  logic [TOTAL_BITS:0]   trial;
  logic [TOTAL_BITS-1:0] rem_next;

  // restoring remainder, one dividend bit per cycle
  always_comb begin
    trial = {rem, dsr[RAND_BITS-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_next = TOTAL_BITS'(trial - {1'b0, divisor});
    end else begin
      rem_next = trial[TOTAL_BITS-1:0];
    end
  end

  assign last = (cnt == STEP_BITS'(RAND_BITS - 1));

  always_ff @(posedge clk) begin
    if (start) begin
      dsr <= dividend;
      rem <= '0;
      cnt <= '0;
    end else if (step) begin
      dsr <= {dsr[RAND_BITS-2:0], 1'b0};
      rem <= rem_next;
      cnt <= cnt + STEP_BITS'(1);
    end
  end

endmodule

// ----- rtl/wrs_dp.sv -----
`include "weighted_random_select_unit_defines.svh"

module wrs_dp import wrs_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  output sts_t                      sts,
  input  logic [MODE_BITS-1:0]      mode,
  input  logic [WEIGHT_IN_BITS-1:0] weight_value,
  input  logic [RAND_BITS-1:0]      random_word,
  output logic [INDEX_OUT_BITS-1:0] chosen_index,
  output logic [STATUS_BITS-1:0]    status
);

  logic [WEIGHT_BITS-1:0] table_mem [MAX_ENTRIES];
  logic [WEIGHT_BITS-1:0] rd_data;
  logic [IDX_BITS-1:0]    rd_addr;

  logic [CNT_BITS-1:0]    entry_count;
  logic [TOTAL_BITS-1:0]  weight_total;
  logic [TOTAL_BITS-1:0]  key;
  logic [TOTAL_BITS-1:0]  rem;
  logic [IDX_BITS-1:0]    idx;
  logic [IDX_BITS-1:0]    res_idx;
  logic [STATUS_BITS-1:0] res_status;

  logic                   full;
  logic                   empty;
  logic [WEIGHT_BITS-1:0] w_in;

  assign w_in  = WEIGHT_BITS'(weight_value);
  assign full  = (entry_count == CNT_BITS'(MAX_ENTRIES));
  assign empty = (entry_count == '0) || (weight_total == '0);

  assign sts.draw_go = (mode == MODE_DRAW) && !empty;
  assign sts.hit     = (key <= TOTAL_BITS'(rd_data));
  assign sts.last    = ((CNT_BITS'(idx) + CNT_BITS'(1)) == entry_count);

  wrs_mod u_mod (
    .clk      (clk),
    .start    (cmd.accept),
    .step     (cmd.mod_step),
    .dividend (random_word),
    .divisor  (weight_total),
    .rem      (rem),
    .last     (sts.mod_last)
  );

  // prefetch the next entry while the current one is compared
  assign rd_addr = cmd.walk_step ? (idx + IDX_BITS'(1)) : '0;

  always_ff @(posedge clk) begin
    if (cmd.accept && mode == MODE_APPEND && !full) begin
      table_mem[entry_count[IDX_BITS-1:0]] <= w_in;
    end
    rd_data <= table_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count  <= '0;
      weight_total <= '0;
    end else if (cmd.accept) begin
      unique case (mode)
        MODE_CLEAR: begin
          entry_count  <= '0;
          weight_total <= '0;
        end
        MODE_APPEND: begin
          if (!full) begin
            entry_count  <= entry_count + CNT_BITS'(1);
            weight_total <= weight_total + TOTAL_BITS'(w_in);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_idx <= '0;
      unique case (mode)
        MODE_APPEND: res_status <= full ? ST_FULL : ST_OK;
        MODE_DRAW:   res_status <= empty ? ST_EMPTY : ST_OK;
        default:     res_status <= ST_OK;
      endcase
    end
    if (cmd.load) begin
      key <= rem + TOTAL_BITS'(1);
      idx <= '0;
    end
    if (cmd.walk_step) begin
      priority if (sts.hit) begin
        res_idx    <= idx;
        res_status <= ST_OK;
      end else if (sts.last) begin
        res_idx    <= '0;
        res_status <= ST_NONE;
      end else begin
        key <= key - TOTAL_BITS'(rd_data);
        idx <= idx + IDX_BITS'(1);
      end
    end
    if (cmd.out_load) begin
      chosen_index <= INDEX_OUT_BITS'(res_idx);
      status       <= res_status;
    end
  end

  `WRS_ASSERT_NOW(a_count_range, clk, rst, 1'b1, entry_count <= CNT_BITS'(MAX_ENTRIES))
  `WRS_ASSERT_NEXT(a_clear_empties, clk, rst, cmd.accept && mode == MODE_CLEAR, entry_count == '0 && weight_total == '0)
  `WRS_ASSERT_NEXT(a_hit_ok, clk, rst, cmd.walk_step && sts.hit, res_status == ST_OK && res_idx == $past(idx))

endmodule

// ----- rtl/wrs_ctrl.sv -----
`include "weighted_random_select_unit_defines.svh"

module wrs_ctrl import wrs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  output logic rsp_valid,
  input  logic rsp_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOD  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_PEND = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);

  assign cmd.accept    = (state == S_IDLE) && req_valid;
  assign cmd.mod_step  = (state == S_MOD);
  assign cmd.load      = (state == S_LOAD);
  assign cmd.walk_step = (state == S_WALK);
  assign cmd.out_load  = (state == S_PEND) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (req_valid) begin
        state_next = sts.draw_go ? S_MOD : S_PEND;
      end
      S_MOD:  if (sts.mod_last) begin
        state_next = S_LOAD;
      end
      S_LOAD: state_next = S_WALK;
      S_WALK: if (sts.hit || sts.last) begin
        state_next = S_PEND;
      end
      S_PEND: if (out_free) begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      // hold the result until the transaction completes
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  `WRS_ASSERT_NEXT(a_mod_to_load, clk, rst, state == S_MOD && sts.mod_last, state == S_LOAD)
  `WRS_ASSERT_NEXT(a_walk_end, clk, rst, state == S_WALK && (sts.hit || sts.last), state == S_PEND)
  `WRS_ASSERT_NEXT(a_out_shown, clk, rst, cmd.out_load, rsp_valid && state == S_IDLE)

endmodule

// ----- rtl/weighted_random_select_unit.sv -----
// Weighted random selection over a table of up to MAX_ENTRIES weights.
// req carries one transaction per command: mode, weight_value, random_word.
//   clear  - empty the table; append - add one weight (status full if none
//   left); draw - key = random_word mod total + 1, return the first index at
//   which the running weight sum reaches the key.
// rsp returns one transaction per command: chosen_index and status.
// Clear, append, the unused mode and a draw on an empty table pass from
// S_IDLE to S_PEND and then into the output register; any other draw passes
// through S_MOD, S_LOAD, S_WALK and S_PEND. The draw time is set by the
// bit-serial remainder unit (one random bit per step) and the walk over the
// table, one entry a cycle through the registered read port.
// One command is in flight at a time; req.ready is high whenever the block
// is idle, also while a finished result still waits in the output register.
// If rsp stalls, the result is held and a completed command waits in the
// controller until the output register frees.
// Reset (synchronous, rst) empties the table and drops any pending result.
module weighted_random_select_unit import wrs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  wrs_in_if.sink    req,
  wrs_out_if.source rsp
);

  cmd_t cmd;
  sts_t sts;

  wrs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wrs_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .mode         (req.mode),
    .weight_value (req.weight_value),
    .random_word  (req.random_word),
    .chosen_index (rsp.chosen_index),
    .status       (rsp.status)
  );

endmodule

// ----- verif/tb_weighted_random_select_unit.sv -----
`timescale 1ns / 100ps

module tb_weighted_random_select_unit;
  import wrs_pkg::*;

  localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 700;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_AFTER   = 300;
  localparam int HOLD_CYCLES  = 400;

  typedef struct {
    logic [MODE_BITS-1:0]      mode;
    logic [WEIGHT_IN_BITS-1:0] weight;
    logic [RAND_BITS-1:0]      rnd;
  } sel_cmd_t;

  typedef struct {
    logic [INDEX_OUT_BITS-1:0] index;
    logic [STATUS_BITS-1:0]    status;
  } sel_result_t;

  logic clk;
  logic rst;

  wrs_in_if  req_if ();
  wrs_out_if rsp_if ();

  weighted_random_select_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  sel_cmd_t    cmd_backlog[$];
  sel_result_t selection_due[$];

  // local copy of the weight table
  logic [WEIGHT_BITS-1:0] wheel_weight[MAX_ENTRIES];
  logic [CNT_BITS-1:0]    wheel_count;
  logic [TOTAL_BITS-1:0]  wheel_total;

  int mismatches;
  int sent_count;
  int cycle_count;
  int burst_left;
  int gap_left;
  int stall_kind;
  int stall_left;
  int hold_left;
  bit hold_done;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    if (mismatches < 10) begin
      $display("%0t: %s", $time, msg);
    end
    mismatches++;
  endtask

  function automatic sel_result_t predict_selection(input sel_cmd_t cmd);
    sel_result_t res;
    logic [31:0] key;
    bit          found;
    res.index  = '0;
    res.status = ST_OK;
    case (cmd.mode)
      MODE_CLEAR: begin
        wheel_count = '0;
        wheel_total = '0;
      end
      MODE_APPEND: begin
        if (wheel_count >= MAX_ENTRIES) begin
          res.status = ST_FULL;
        end else begin
          wheel_weight[wheel_count[IDX_BITS-1:0]] = cmd.weight[WEIGHT_BITS-1:0];
          wheel_count = wheel_count + CNT_BITS'(1);
          wheel_total = wheel_total + TOTAL_BITS'(cmd.weight[WEIGHT_BITS-1:0]);
        end
      end
      MODE_DRAW: begin
        if (wheel_count == 0 || wheel_total == 0) begin
          res.status = ST_EMPTY;
        end else begin
          key   = 32'(cmd.rnd) % 32'(wheel_total) + 32'd1;
          found = 1'b0;
          for (int i = 0; i < wheel_count && !found; i++) begin
            if (key <= 32'(wheel_weight[i])) begin
              res.index = INDEX_OUT_BITS'(i);
              found     = 1'b1;
            end else begin
              key = key - 32'(wheel_weight[i]);
            end
          end
          if (!found) begin
            res.status = ST_NONE;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic queue_cmd(input logic [MODE_BITS-1:0] mode,
                           input logic [WEIGHT_IN_BITS-1:0] weight,
                           input logic [RAND_BITS-1:0] rnd);
    sel_cmd_t cmd;
    cmd.mode   = mode;
    cmd.weight = weight;
    cmd.rnd    = rnd;
    cmd_backlog.insert(cmd_backlog.size(), cmd);
  endtask

  function automatic logic [WEIGHT_IN_BITS-1:0] pick_weight();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return WEIGHT_IN_BITS'($urandom_range(1, 15));
      default: return WEIGHT_IN_BITS'($urandom());
    endcase
  endfunction

  function automatic logic [RAND_BITS-1:0] pick_random();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return RAND_BITS'($urandom_range(0, 255));
      default: return RAND_BITS'($urandom());
    endcase
  endfunction

  // driver: bursts of transactions separated by random gaps
  always @(posedge clk) begin
    sel_cmd_t cmd;
    logic     next_valid;
    if (rst) begin
      req_if.valid <= 1'b0;
      burst_left = $urandom_range(1, 20);
      gap_left   = 0;
    end else begin
      next_valid = req_if.valid;
      if (req_if.valid && req_if.ready) begin
        cmd.mode   = req_if.mode;
        cmd.weight = req_if.weight_value;
        cmd.rnd    = req_if.random_word;
        selection_due.insert(selection_due.size(), predict_selection(cmd));
        sent_count++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_backlog.size() != 0) begin
          cmd = cmd_backlog.pop_front();
          req_if.mode         <= cmd.mode;
          req_if.weight_value <= cmd.weight;
          req_if.random_word  <= cmd.rnd;
          next_valid = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      req_if.valid <= next_valid;
    end
  end

  // long hold-off on the result side so that the block backs up
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && sent_count >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: check each result transaction and drive the stall pattern
  always @(posedge clk) begin
    sel_result_t want;
    bit          take;
    if (rst) begin
      rsp_if.ready <= 1'b0;
      stall_kind = 0;
      stall_left = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (selection_due.size() == 0) begin
          flag_error($sformatf("unexpected result index=%0d status=%0d",
                               rsp_if.chosen_index, rsp_if.status));
        end else begin
          want = selection_due.pop_front();
          if (rsp_if.chosen_index !== want.index || rsp_if.status !== want.status) begin
            flag_error($sformatf("result mismatch: expected index=%0d status=%0d, got index=%0d status=%0d",
                                 want.index, want.status,
                                 rsp_if.chosen_index, rsp_if.status));
          end
        end
      end
      if (stall_left == 0) begin
        stall_kind = $urandom_range(0, 3);
        stall_left = $urandom_range(4, 60);
      end else begin
        stall_left--;
      end
      case (stall_kind)
        2:       take = ($urandom_range(0, 1) == 0);
        3:       take = ($urandom_range(0, 3) == 0);
        default: take = 1'b1;
      endcase
      rsp_if.ready <= take && (hold_left == 0);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int n_add;
    int n_draw;
    rst                 = 1'b1;
    req_if.valid        = 1'b0;
    req_if.mode         = MODE_CLEAR;
    req_if.weight_value = '0;
    req_if.random_word  = '0;
    rsp_if.ready        = 1'b0;
    mismatches          = 0;
    sent_count          = 0;
    cycle_count         = 0;
    wheel_count         = '0;
    wheel_total         = '0;

    // directed: empty table, zero total, unused mode, full table, extremes
    queue_cmd(MODE_DRAW, '0, '1);
    queue_cmd(MODE_APPEND, '0, '1);
    queue_cmd(MODE_DRAW, '1, '0);
    queue_cmd(MODE_UNUSED, '1, '1);
    for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
      queue_cmd(MODE_APPEND, '1, '0);
    end
    queue_cmd(MODE_APPEND, 16'h0001, '0);
    queue_cmd(MODE_DRAW, '0, '0);
    queue_cmd(MODE_DRAW, '0, '1);
    queue_cmd(MODE_DRAW, '0, RAND_BITS'((MAX_ENTRIES - 1) * 65535));
    queue_cmd(MODE_CLEAR, '1, '1);
    queue_cmd(MODE_DRAW, '0, '1);

    // random: mostly build-and-draw sequences, some stray commands
    while (cmd_backlog.size() < RANDOM_ITEMS + 25) begin
      if ($urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 3) != 0) begin
          queue_cmd(MODE_CLEAR, WEIGHT_IN_BITS'($urandom()), RAND_BITS'($urandom()));
        end
        n_add  = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 19) : $urandom_range(1, 6);
        n_draw = $urandom_range(1, 6);
        for (int i = 0; i < n_add; i++) begin
          queue_cmd(MODE_APPEND, pick_weight(), RAND_BITS'($urandom()));
        end
        for (int i = 0; i < n_draw; i++) begin
          queue_cmd(MODE_DRAW, WEIGHT_IN_BITS'($urandom()), pick_random());
        end
      end else begin
        queue_cmd(MODE_BITS'($urandom_range(0, 3)), WEIGHT_IN_BITS'($urandom()),
                  RAND_BITS'($urandom()));
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (cmd_backlog.size() != 0 || req_if.valid) @(posedge clk);
    while (selection_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (selection_due.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", selection_due.size()));
    end

    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
